### rtl/core/buddy_page_allocator_unit_defines.svh
// Assertion macros for the allocator RTL (included by bpa_dp).
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on clk, off while rst_n is low.
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk, also during reset.
`define BPA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_NR(lbl, prop, msg)
`endif

`endif

### rtl/core/bpa_pkg.sv
package bpa_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_SPLIT,
    ST_FCHK,
    ST_FRD,
    ST_BCHK,
    ST_FWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic split;
    logic alloc_fin;
    logic fail;
    logic fhead;
    logic free_skip;
    logic frd;
    logic merge;
    logic free_fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic oversize;
    logic scan_done;
    logic found;
    logic split_done;
    logic head_ok;
    logic at_top;
    logic buddy_ok;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/bpa_ctl.sv
module bpa_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bpa_pkg::dp_sts_t sts,
  output bpa_pkg::dp_cmd_t cmd
);

  bpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      bpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bpa_pkg::ST_PREP;
        end
      end
      bpa_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
        if (sts.is_free) begin
          state_nxt = bpa_pkg::ST_FCHK;
        end else if (sts.oversize) begin
          cmd.fail  = 1'b1;
          state_nxt = bpa_pkg::ST_DONE;
        end else begin
          state_nxt = bpa_pkg::ST_SCAN;
        end
      end
      bpa_pkg::ST_SCAN: begin
        if (!sts.scan_done) begin
          cmd.scan = 1'b1;
        end else if (sts.found) begin
          state_nxt = bpa_pkg::ST_SPLIT;
        end else begin
          cmd.fail  = 1'b1;
          state_nxt = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_SPLIT: begin
        if (sts.split_done) begin
          cmd.alloc_fin = 1'b1;
          state_nxt     = bpa_pkg::ST_DONE;
        end else begin
          cmd.split = 1'b1;
        end
      end
      bpa_pkg::ST_FCHK: begin
        if (sts.head_ok) begin
          cmd.fhead = 1'b1;
          state_nxt = bpa_pkg::ST_FRD;
        end else begin
          cmd.free_skip = 1'b1;
          state_nxt     = bpa_pkg::ST_DONE;
        end
      end
      bpa_pkg::ST_FRD: begin
        if (sts.at_top) begin
          state_nxt = bpa_pkg::ST_FWR;
        end else begin
          cmd.frd   = 1'b1;
          state_nxt = bpa_pkg::ST_BCHK;
        end
      end
      bpa_pkg::ST_BCHK: begin
        if (sts.buddy_ok) begin
          cmd.merge = 1'b1;
          state_nxt = bpa_pkg::ST_FRD;
        end else begin
          state_nxt = bpa_pkg::ST_FWR;
        end
      end
      bpa_pkg::ST_FWR: begin
        cmd.free_fin = 1'b1;
        state_nxt    = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bpa_dp.sv
`include "buddy_page_allocator_unit_defines.svh"

module bpa_dp #(
  parameter int PAGE_BITS = 12,
  parameter int POOL_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bpa_pkg::dp_cmd_t cmd,
  output bpa_pkg::dp_sts_t sts,
  input  logic             in_mode,
  input  logic [20:0]      in_request_bytes,
  input  logic [7:0]       in_free_page,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_granted_page,
  output logic [3:0]       out_granted_order,
  output logic             out_success
);

  localparam int TOP_ORDER = POOL_BITS - PAGE_BITS;
  localparam int PW        = TOP_ORDER;
  localparam int NP        = 1 << TOP_ORDER;
  localparam int OW        = $clog2(TOP_ORDER + 1);
  localparam int EW        = OW + 2;

  // entry layout: {head, free, order}
  localparam logic [EW-1:0] ENT_TOP = {1'b1, 1'b1, OW'(TOP_ORDER)};

  logic          mode_r;
  logic [20:0]   bytes_r;
  logic [PW-1:0] cur_r;
  logic [OW-1:0] ord_r;
  logic [OW-1:0] want_r;
  logic [PW:0]   scan_addr_r;
  logic          ev_pend_r;
  logic [PW-1:0] ev_addr_r;
  logic          best_found_r;
  logic [PW-1:0] best_page_r;
  logic [OW-1:0] best_ord_r;
  logic [PW-1:0] res_page_r;
  logic [OW-1:0] res_ord_r;
  logic          res_ok_r;
  logic          out_valid_r;
  logic [7:0]    out_page_r;
  logic [3:0]    out_ord_r;
  logic          out_ok_r;
  logic [NP-1:0] vld_r;
  logic          rd_vld_r;
  logic          rd_zero_r;

  logic [OW-1:0] want_c;
  logic          oversize_c;
  logic [PW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] ent;
  logic          ent_head;
  logic          ent_free;
  logic [OW-1:0] ent_ord;
  logic [PW-1:0] buddy;
  logic [PW-1:0] upper;
  logic          better;

  // Round the byte count up to a power-of-two number of pages.
  always_comb begin
    want_c = OW'(TOP_ORDER);
    for (int w = TOP_ORDER; w >= 0; w--) begin
      if (64'(bytes_r) <= (64'd1 << (PAGE_BITS + w))) begin
        want_c = OW'(w);
      end
    end
  end

  assign oversize_c = 64'(bytes_r) > (64'd1 << POOL_BITS);

  // Never-written entries read as the reset pool: one free top block at page zero.
  assign ent      = rd_vld_r ? rd_data : (rd_zero_r ? ENT_TOP : '0);
  assign ent_head = ent[EW-1];
  assign ent_free = ent[EW-2];
  assign ent_ord  = ent[OW-1:0];

  assign buddy  = cur_r ^ (PW'(1) << ord_r);
  assign upper  = best_page_r + (PW'(1) << (best_ord_r - OW'(1)));
  assign better = ev_pend_r && ent_head && ent_free && (ent_ord >= want_r) &&
                  (!best_found_r || (ent_ord < best_ord_r));

  always_comb begin
    rd_addr = cur_r;
    if (cmd.scan) begin
      rd_addr = scan_addr_r[PW-1:0];
    end else if (cmd.frd) begin
      rd_addr = buddy;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = '0;
    if (cmd.split) begin
      wr_en   = 1'b1;
      wr_addr = upper;
      wr_data = {1'b1, 1'b1, best_ord_r - OW'(1)};
    end else if (cmd.alloc_fin) begin
      wr_en   = 1'b1;
      wr_addr = best_page_r;
      wr_data = {1'b1, 1'b0, want_r};
    end else if (cmd.merge) begin
      wr_en   = 1'b1;
      wr_addr = (buddy > cur_r) ? buddy : cur_r;
      wr_data = '0;
    end else if (cmd.free_fin) begin
      wr_en   = 1'b1;
      wr_addr = cur_r;
      wr_data = {1'b1, 1'b1, ord_r};
    end
  end

  bpa_ram #(
    .WIDTH(EW),
    .DEPTH(NP)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r  <= vld_r[rd_addr];
    rd_zero_r <= (rd_addr == '0);
    if (cmd.load) begin
      mode_r  <= in_mode;
      bytes_r <= in_request_bytes;
      cur_r   <= PW'(in_free_page);
    end
    if (cmd.prep) begin
      want_r       <= want_c;
      scan_addr_r  <= '0;
      ev_pend_r    <= 1'b0;
      best_found_r <= 1'b0;
    end
    if (cmd.scan) begin
      ev_addr_r <= scan_addr_r[PW-1:0];
      ev_pend_r <= (scan_addr_r < (PW+1)'(NP));
      if (scan_addr_r < (PW+1)'(NP)) begin
        scan_addr_r <= scan_addr_r + ((PW+1)'(1) << want_r);
      end
      if (better) begin
        best_found_r <= 1'b1;
        best_page_r  <= ev_addr_r;
        best_ord_r   <= ent_ord;
      end
    end
    if (cmd.split) begin
      best_ord_r <= best_ord_r - OW'(1);
    end
    if (cmd.fhead) begin
      ord_r <= ent_ord;
    end
    if (cmd.merge) begin
      cur_r <= (buddy < cur_r) ? buddy : cur_r;
      ord_r <= ord_r + OW'(1);
    end
    if (cmd.alloc_fin) begin
      res_page_r <= best_page_r;
      res_ord_r  <= want_r;
      res_ok_r   <= 1'b1;
    end
    if (cmd.fail) begin
      res_page_r <= '0;
      res_ord_r  <= '0;
      res_ok_r   <= 1'b0;
    end
    if (cmd.free_skip || cmd.free_fin) begin
      res_page_r <= '0;
      res_ord_r  <= '0;
      res_ok_r   <= 1'b1;
    end
    if (cmd.emit) begin
      out_page_r <= 8'(res_page_r);
      out_ord_r  <= 4'(res_ord_r);
      out_ok_r   <= res_ok_r;
    end
  end

  always_comb begin
    sts            = '0;
    sts.is_free    = mode_r;
    sts.oversize   = oversize_c;
    sts.scan_done  = ((scan_addr_r >= (PW+1)'(NP)) && !ev_pend_r) ||
                     (best_found_r && (best_ord_r == want_r));
    sts.found      = best_found_r;
    sts.split_done = (best_ord_r == want_r);
    sts.head_ok    = ent_head && !ent_free && (ent_ord <= OW'(TOP_ORDER));
    sts.at_top     = (ord_r == OW'(TOP_ORDER));
    sts.buddy_ok   = ent_head && ent_free && (ent_ord == ord_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_page  = out_page_r;
  assign out_granted_order = out_ord_r;
  assign out_success       = out_ok_r;

  `BPA_ASSERT(a_split_above_want, cmd.split |-> (best_ord_r > want_r), "split below request")
  `BPA_ASSERT(a_merge_below_top, cmd.merge |-> (ord_r < OW'(TOP_ORDER)), "merge past top")
  `BPA_ASSERT(a_grant_aligned,
    cmd.alloc_fin |-> ((best_page_r & ((PW'(1) << want_r) - PW'(1))) == '0),
    "grant misaligned")
  `BPA_ASSERT(a_emit_shows, cmd.emit |=> out_valid_r, "result lost")
  `BPA_ASSERT_NR(a_reset_quiet, !rst_n |=> !out_valid_r, "result after reset")

endmodule

### rtl/core/buddy_page_allocator_unit.sv
// Buddy page allocator over 2^(POOL_BITS-PAGE_BITS) pages.
// Input channel (in_valid/in_ready): in_mode 0 allocates in_request_bytes,
// in_mode 1 frees the block that starts at in_free_page.
// Result channel (out_valid/out_ready): one result item per input item with
// the granted page, its order and a success flag (0 only for a failed
// allocation; free results carry page 0, order 0).
// One item at a time: a new item is taken once the previous one is finished.
// Allocation: a free-block scan reads the page table through one RAM port
// at one entry per cycle, stepping by the request size and cut short when a
// block of the exact order turns up; the found block is then split one
// level at a time down to the requested order.
// Free: head check, then a buddy read and a merge per level, then a final write.
// Reset: per-page valid bits clear at once, so the pool is a single free
// top-order block with no clearing pass.
// A stalled result waits in the output register; the block finishes its
// current item and holds that result until the output register is free.
module buddy_page_allocator_unit #(
  parameter int PAGE_BITS = 12,
  parameter int POOL_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [20:0] in_request_bytes,
  input  logic [7:0]  in_free_page,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_granted_page,
  output logic [3:0]  out_granted_order,
  output logic        out_success
);

  bpa_pkg::dp_cmd_t cmd;
  bpa_pkg::dp_sts_t sts;

  bpa_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bpa_dp #(
    .PAGE_BITS(PAGE_BITS),
    .POOL_BITS(POOL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_request_bytes (in_request_bytes),
    .in_free_page     (in_free_page),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_page (out_granted_page),
    .out_granted_order(out_granted_order),
    .out_success      (out_success)
  );

endmodule
